// ----- sv/cemi_pkg.sv -----
// shared constants and types for the cemi data frame parser
// no dependencies; used by cemi_data_frame_parser_top
`default_nettype none

package cemi_pkg;

  // byte position counter saturates at this value
  localparam int unsigned MAX_FRAME_BYTES = 511;
  localparam int unsigned POS_W           = $clog2(MAX_FRAME_BYTES + 1);
  // one extra bit so that position plus offsets never wraps
  localparam int unsigned CMP_W           = POS_W + 1;

  // supported message codes
  localparam logic [7:0] CODE_DATA_REQ = 8'h11;
  localparam logic [7:0] CODE_DATA_IND = 8'h29;

  // frame layout, offsets after the additional information
  localparam logic [3:0] OFS_SRC_HI = 4'd4;
  localparam logic [3:0] OFS_SRC_LO = 4'd5;
  localparam logic [3:0] OFS_DST_HI = 4'd6;
  localparam logic [3:0] OFS_DST_LO = 4'd7;
  localparam logic [3:0] OFS_OP_HI  = 4'd9;
  localparam logic [3:0] OFS_OP_LO  = 4'd10;
  localparam logic [3:0] MIN_FRAME  = 4'd11;

  localparam logic [7:0] OP_HI_MASK    = 8'h03;
  localparam logic [7:0] OP_LO_MASK    = 8'hC0;
  localparam logic [7:0] SHORT_PAY_MASK = 8'h3F;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_BAD_CODE  = 2'd2,
    ST_TOO_SMALL = 2'd3
  } parse_status_e;

endpackage

`default_nettype wire

// ----- sv/cemi_data_frame_parser_top.sv -----
// cemi l_data frame parser, byte stream in, payload and frame summary out
// depends on cemi_pkg
`default_nettype none

// Usage:
//  s_axis carries one frame byte per word in tdata, tlast on the frame's last byte.
//  m_axis gives one result word for every payload byte and for every frame's
//  last byte; bytes of the header produce no word. tuser flags a payload byte,
//  tlast marks the frame summary (addresses, operation, status in tdata).
//  A word accepted into the input register is parsed into the result register,
//  which drives m_axis. Throughput: one byte per cycle while m_axis does not stall,
//  set by the single parse stage between the input and the result register.
//  When m_axis stalls, the parse stage holds its word only if that word
//  makes a result; the input register keeps it and s_axis_tready drops.
//  Header-only words keep flowing through a stalled output.
//  Reset clears both valid flags and the parse state (byte position, message
//  code, info length, addresses, operation); the next byte starts a frame.
module cemi_data_frame_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // frame_last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [7:0] payload_byte, [23:8] source_address,
                                           // [39:24] destination_address,
                                           // [43:40] operation_code, [45:44] parse_status,
                                           // [47:46] zero
  output logic             m_axis_tlast,   // frame_end
  output logic             m_axis_tuser    // payload_valid
);

  localparam int unsigned POS_W = cemi_pkg::POS_W;
  localparam int unsigned CMP_W = cemi_pkg::CMP_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(cemi_pkg::MAX_FRAME_BYTES);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // parse state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       code_q, code_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      src_q, src_d;
  logic [15:0]      dst_q, dst_d;
  logic [3:0]       op_q, op_d;

  // result register
  logic        out_valid_q;
  logic        out_pay_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic [15:0] out_src_q;
  logic [15:0] out_dst_q;
  logic [3:0]  out_op_q;
  cemi_pkg::parse_status_e out_status_q;

  logic             supported;
  logic [CMP_W-1:0] posx, lenx, rel, size;
  logic             in_window;
  logic             pay;
  logic [7:0]       pbyte;
  logic             emit;
  logic             out_free;
  logic             advance;
  cemi_pkg::parse_status_e status;

  always_comb begin
    code_d = (pos_q == '0) ? in_byte_q : code_q;
    len_d  = (pos_q == POS_W'(1)) ? in_byte_q : len_q;
    supported = (code_d == cemi_pkg::CODE_DATA_REQ) || (code_d == cemi_pkg::CODE_DATA_IND);

    posx = {1'b0, pos_q};
    lenx = CMP_W'(len_d);
    rel  = posx - lenx;
    in_window = (posx >= lenx + CMP_W'(cemi_pkg::OFS_SRC_HI)) &&
                (posx <= lenx + CMP_W'(cemi_pkg::OFS_OP_LO));

    src_d = src_q;
    dst_d = dst_q;
    op_d  = op_q;
    if (in_window) begin
      case (rel[3:0])
        cemi_pkg::OFS_SRC_HI: src_d[15:8] = in_byte_q;
        cemi_pkg::OFS_SRC_LO: src_d[7:0]  = in_byte_q;
        cemi_pkg::OFS_DST_HI: dst_d[15:8] = in_byte_q;
        cemi_pkg::OFS_DST_LO: dst_d[7:0]  = in_byte_q;
        cemi_pkg::OFS_OP_HI:  op_d[3:2]   = in_byte_q[1:0];
        cemi_pkg::OFS_OP_LO:  op_d[1:0]   = in_byte_q[7:6];
        default: ;
      endcase
    end

    pay   = 1'b0;
    pbyte = '0;
    if (supported) begin
      if (posx >= lenx + CMP_W'(cemi_pkg::MIN_FRAME)) begin
        pay   = 1'b1;
        pbyte = in_byte_q;
      end else if (in_last_q && in_window && (rel[3:0] == cemi_pkg::OFS_OP_LO)) begin
        // frame ends on the operation byte: its low six bits are the payload
        pay   = 1'b1;
        pbyte = in_byte_q & cemi_pkg::SHORT_PAY_MASK;
      end
    end

    size = posx + CMP_W'(1);
    if (!supported) begin
      status = cemi_pkg::ST_BAD_CODE;
    end else if (size < CMP_W'(cemi_pkg::MIN_FRAME)) begin
      status = cemi_pkg::ST_TOO_SMALL;
    end else if (size < lenx + CMP_W'(cemi_pkg::MIN_FRAME)) begin
      status = cemi_pkg::ST_SHORT;
    end else begin
      status = cemi_pkg::ST_OK;
    end

    if (in_last_q) begin
      pos_d = '0;
    end else if (pos_q < POS_MAX) begin
      pos_d = pos_q + POS_W'(1);
    end else begin
      pos_d = POS_MAX;
    end

    emit = pay || in_last_q;
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  // header words need no room in the result register
  assign advance       = in_valid_q && (!emit || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      code_q      <= '0;
      len_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      op_q        <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        pos_q  <= pos_d;
        code_q <= code_d;
        len_q  <= len_d;
        src_q  <= src_d;
        dst_q  <= dst_d;
        op_q   <= op_d;
      end
      if (out_free) begin
        out_valid_q <= advance && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && emit) begin
      out_pay_q  <= pay;
      out_byte_q <= pbyte;
      out_last_q <= in_last_q;
      if (in_last_q && (status == cemi_pkg::ST_OK)) begin
        out_src_q <= src_d;
        out_dst_q <= dst_d;
        out_op_q  <= op_d;
      end else begin
        out_src_q <= '0;
        out_dst_q <= '0;
        out_op_q  <= '0;
      end
      out_status_q <= in_last_q ? status : cemi_pkg::ST_OK;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_pay_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_status_q, out_op_q, out_dst_q, out_src_q, out_byte_q};

`ifndef SYNTHESIS
  // a word without payload must be a frame summary with zero payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_pay_q |-> out_last_q && (out_byte_q == '0))
    else $error("result without payload is not a frame end");

  // summaries only carry a status on the frame end word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> (out_status_q == cemi_pkg::ST_OK) &&
      (out_src_q == '0) && (out_dst_q == '0) && (out_op_q == '0))
    else $error("summary fields set on a non frame end word");

  // failed parses report no addresses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != cemi_pkg::ST_OK) |->
      (out_src_q == '0) && (out_dst_q == '0) && (out_op_q == '0))
    else $error("addresses reported on a failed parse");

  // last byte of a frame restarts the byte position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> pos_q == '0)
    else $error("byte position not cleared after frame end");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_cemi_data_frame_parser_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for cemi_data_frame_parser_top, byte stream in, results checked out
// depends on cemi_pkg and the parser rtl; predicts each result word with a local parser model

module tb_cemi_data_frame_parser_top;

  typedef logic [7:0] frame_bytes_t[$];

  typedef struct packed {
    logic                    payload_valid;
    logic [7:0]              payload_byte;
    logic                    frame_end;
    logic [15:0]             source_address;
    logic [15:0]             destination_address;
    logic [3:0]              operation_code;
    cemi_pkg::parse_status_e parse_status;
  } frame_result_t;

  localparam int unsigned SRC_HI_OFS = 32'(cemi_pkg::OFS_SRC_HI);
  localparam int unsigned OP_LO_OFS  = 32'(cemi_pkg::OFS_OP_LO);
  localparam int unsigned MIN_LEN    = 32'(cemi_pkg::MIN_FRAME);

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic        s_axis_tlast  = 1'b0; // frame_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // [7:0] payload_byte, [23:8] source_address,
                                     // [39:24] destination_address, [43:40] operation_code,
                                     // [45:44] parse_status, [47:46] zero
  logic        m_axis_tlast;         // frame_end
  logic        m_axis_tuser;         // payload_valid

  // local copy of the parse state
  int unsigned byte_pos;
  logic [7:0]  msg_code;
  logic [7:0]  info_len;
  logic [15:0] src_addr;
  logic [15:0] dst_addr;
  logic [3:0]  op_code;

  frame_result_t expected_words[$];
  int unsigned   err_count      = 0;
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;

  cemi_data_frame_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("tb_cemi_data_frame_parser_top: errors");
    $finish;
  end

  // parses one accepted byte, returns 1 when it makes a result word
  function automatic bit parse_frame_byte(input logic [7:0] b, input logic last,
                                          output frame_result_t r);
    int unsigned             pos;
    int unsigned             len;
    int unsigned             size;
    bit                      supported;
    bit                      pay;
    logic [7:0]              pbyte;
    cemi_pkg::parse_status_e st;
    pos = byte_pos;
    if (pos == 0) msg_code = b;
    if (pos == 1) info_len = b;
    len = 32'(info_len);
    supported = (msg_code == cemi_pkg::CODE_DATA_REQ) || (msg_code == cemi_pkg::CODE_DATA_IND);
    if (pos >= SRC_HI_OFS + len && pos <= OP_LO_OFS + len) begin
      case (4'(pos - len))
        cemi_pkg::OFS_SRC_HI: src_addr[15:8] = b;
        cemi_pkg::OFS_SRC_LO: src_addr[7:0]  = b;
        cemi_pkg::OFS_DST_HI: dst_addr[15:8] = b;
        cemi_pkg::OFS_DST_LO: dst_addr[7:0]  = b;
        cemi_pkg::OFS_OP_HI:  op_code[3:2]   = b[1:0];
        cemi_pkg::OFS_OP_LO:  op_code[1:0]   = b[7:6];
        default: ;
      endcase
    end
    pay   = 1'b0;
    pbyte = '0;
    if (supported) begin
      if (pos >= MIN_LEN + len) begin
        pay   = 1'b1;
        pbyte = b;
      end else if (last && pos == OP_LO_OFS + len) begin
        // frame ends on the operation byte: its low bits are the payload
        pay   = 1'b1;
        pbyte = b & cemi_pkg::SHORT_PAY_MASK;
      end
    end
    size = pos + 1;
    if (!supported)                st = cemi_pkg::ST_BAD_CODE;
    else if (size < MIN_LEN)       st = cemi_pkg::ST_TOO_SMALL;
    else if (size < MIN_LEN + len) st = cemi_pkg::ST_SHORT;
    else                           st = cemi_pkg::ST_OK;
    r = '0;
    r.payload_valid = pay;
    r.payload_byte  = pbyte;
    r.frame_end     = last;
    if (last) begin
      r.parse_status = st;
      if (st == cemi_pkg::ST_OK) begin
        r.source_address      = src_addr;
        r.destination_address = dst_addr;
        r.operation_code      = op_code;
      end
    end
    if (last)                                 byte_pos = 0;
    else if (pos < cemi_pkg::MAX_FRAME_BYTES) byte_pos = pos + 1;
    else                                      byte_pos = cemi_pkg::MAX_FRAME_BYTES;
    return pay || last;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    frame_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: tdata 0x%0h", m_axis_tdata);
        err_count++;
      end else begin
        exp_r = expected_words.pop_front();
        check_field("payload_valid", 16'(exp_r.payload_valid), 16'(m_axis_tuser));
        check_field("payload_byte", 16'(exp_r.payload_byte), 16'(m_axis_tdata[7:0]));
        check_field("frame_end", 16'(exp_r.frame_end), 16'(m_axis_tlast));
        check_field("source_address", exp_r.source_address, m_axis_tdata[23:8]);
        check_field("destination_address", exp_r.destination_address, m_axis_tdata[39:24]);
        check_field("operation_code", 16'(exp_r.operation_code), 16'(m_axis_tdata[43:40]));
        check_field("parse_status", 16'(exp_r.parse_status), 16'(m_axis_tdata[45:44]));
        check_field("tdata pad", 16'h0, 16'(m_axis_tdata[47:46]));
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    frame_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (parse_frame_byte(b, last, r)) expected_words = {expected_words, r};
  endtask

  task automatic send_frame(input frame_bytes_t frame);
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic build_frame(input logic [7:0] code, input int unsigned len,
                             input int unsigned nbytes, output frame_bytes_t frame);
    frame = {};
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (i == 0)      frame = {frame, code};
      else if (i == 1) frame = {frame, len[7:0]};
      else             frame = {frame, 8'($urandom_range(255))};
    end
  endtask

  task automatic test_directed();
    // operation byte ends the frame: short payload, all-ones operation
    send_frame('{cemi_pkg::CODE_DATA_REQ, 8'h00, 8'hBC, 8'hE0, 8'hFF, 8'hFF, 8'h00, 8'h01,
                 8'h00, 8'h03, 8'hFF});
    // one payload byte after the header, zero operation
    send_frame('{cemi_pkg::CODE_DATA_IND, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'hFF, 8'h00,
                 8'h00, 8'h00, 8'h3F, 8'h00});
    // unsupported code on a single byte
    send_frame('{8'hFF});
    // supported code, far below the minimum length
    send_frame('{cemi_pkg::CODE_DATA_IND, 8'hFF});
  endtask

  task automatic test_random_frames(input int unsigned idle_pct, input int unsigned stall_pct,
                                    input int unsigned n_items);
    frame_bytes_t frame;
    int unsigned  sent;
    int unsigned  pick;
    logic [7:0]   code;
    int unsigned  len;
    int unsigned  nbytes;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45)      code = cemi_pkg::CODE_DATA_REQ;
      else if (pick < 90) code = cemi_pkg::CODE_DATA_IND;
      else                code = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 80)      len = $urandom_range(3);
      else if (pick < 96) len = $urandom_range(16, 4);
      else                len = $urandom_range(255, 17);
      pick = $urandom_range(99);
      if (pick < 75)      nbytes = $urandom_range(MIN_LEN + len + 6, MIN_LEN + len);
      else if (pick < 90) nbytes = $urandom_range(OP_LO_OFS + len, 1);
      else                nbytes = $urandom_range(40, 1);
      build_frame(code, len, nbytes, frame);
      send_frame(frame);
      sent += nbytes;
    end
  endtask

  // frame long enough to pin the byte position at its top value
  task automatic test_long_frame();
    frame_bytes_t frame;
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    build_frame(cemi_pkg::CODE_DATA_IND, 2, cemi_pkg::MAX_FRAME_BYTES + 3, frame);
    send_frame(frame);
  endtask

  // sender holds off until every result word is back
  task automatic test_pause_between_frames();
    frame_bytes_t frame;
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    for (int unsigned k = 0; k < 2; k++) begin
      build_frame(cemi_pkg::CODE_DATA_REQ, k, MIN_LEN + k + 2, frame);
      send_frame(frame);
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (expected_words.size() != 0);
    end
  endtask

  initial begin
    byte_pos = 0;
    msg_code = '0;
    info_len = '0;
    src_addr = '0;
    dst_addr = '0;
    op_code  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_frames(0, 0, 12);
    test_random_frames(62, 0, 12);
    test_random_frames(0, 62, 12);
    test_random_frames(38, 38, 12);
    test_pause_between_frames();
    test_long_frame();

    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 20;
    do @(posedge clk_i); while (expected_words.size() != 0);
    repeat (10) @(posedge clk_i);

    if (err_count == 0 && expected_words.size() == 0) begin
      $display("tb_cemi_data_frame_parser_top: clean");
    end else begin
      $display("tb_cemi_data_frame_parser_top: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/cemi_pkg.sv
sv/cemi_data_frame_parser_top.sv
dv/tb_cemi_data_frame_parser_top.sv
